// ===== src/wsmt_pkg.sv =====
package wsmt_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int ADDR_W     = $clog2(MAX_POINTS);
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  localparam int CRD_W  = 20;
  localparam int WGT_W  = 16;
  localparam int VAL_W  = 64;
  localparam int CRD3_W = 3 * CRD_W;

  // first pass: weighted coordinate sums and total weight
  localparam int P1_W  = CRD_W + WGT_W + 1;
  localparam int SUM_W = P1_W + CNT_W;
  localparam int TOT_W = WGT_W + CNT_W;

  // second pass: offsets, products, tensor terms, weighted terms
  localparam int D_W   = CRD_W + 1;
  localparam int PRD_W = 2 * D_W;
  localparam int F_W   = PRD_W + 1;
  localparam int WF_W  = F_W + WGT_W + 1;
  localparam int ACC_W = WF_W + CNT_W + 1;

  // divider operands
  localparam int NUM_W  = (SUM_W > PRD_W + CNT_W) ? SUM_W : PRD_W + CNT_W;
  localparam int DEN_W  = TOT_W;
  localparam int DCNT_W = $clog2(NUM_W + 1);

  localparam int NUM_U  = 6;
  localparam int ELEMS  = 9;
  localparam int ELEM_W = $clog2(ELEMS);

  localparam logic [2:0] U_XX = 3'd0;
  localparam logic [2:0] U_YY = 3'd1;
  localparam logic [2:0] U_ZZ = 3'd2;
  localparam logic [2:0] U_XY = 3'd3;
  localparam logic [2:0] U_XZ = 3'd4;
  localparam logic [2:0] U_YZ = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_SAT   = 2'd2;
  localparam logic [1:0] STAT_DROP  = 2'd3;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SUM,
    ST_CDIV,
    ST_MOM,
    ST_NDIV,
    ST_SAT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic [DEN_W-1:0]        den;
  } div_req_t;

  typedef struct packed {
    logic [1:0] row;
    logic [1:0] col;
    logic [2:0] u;
  } elem_t;

  // row-major element order onto the six distinct tensor terms
  function automatic elem_t elem_map(input logic [ELEM_W-1:0] e);
    elem_t m;
    case (e)
      4'd0:    m = '{row: 2'd0, col: 2'd0, u: U_XX};
      4'd1:    m = '{row: 2'd0, col: 2'd1, u: U_XY};
      4'd2:    m = '{row: 2'd0, col: 2'd2, u: U_XZ};
      4'd3:    m = '{row: 2'd1, col: 2'd0, u: U_XY};
      4'd4:    m = '{row: 2'd1, col: 2'd1, u: U_YY};
      4'd5:    m = '{row: 2'd1, col: 2'd2, u: U_YZ};
      4'd6:    m = '{row: 2'd2, col: 2'd0, u: U_XZ};
      4'd7:    m = '{row: 2'd2, col: 2'd1, u: U_YZ};
      default: m = '{row: 2'd2, col: 2'd2, u: U_ZZ};
    endcase
    return m;
  endfunction

endpackage

// ===== src/wsmt_if.sv =====
interface wsmt_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [wsmt_pkg::CRD_W-1:0] pos_x;
  logic signed [wsmt_pkg::CRD_W-1:0] pos_y;
  logic signed [wsmt_pkg::CRD_W-1:0] pos_z;
  logic [wsmt_pkg::WGT_W-1:0]        weight;
  logic                              last_point;

  modport source (output valid, pos_x, pos_y, pos_z, weight, last_point, input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, weight, last_point, output ready);
endinterface

interface wsmt_out_if;
  logic                              valid;
  logic                              ready;
  logic [1:0]                        row;
  logic [1:0]                        col;
  logic signed [wsmt_pkg::VAL_W-1:0] value;
  logic [1:0]                        status;
  logic                              last_element;

  modport source (output valid, row, col, value, status, last_element, input ready);
  modport sink   (input valid, row, col, value, status, last_element, output ready);
endinterface

// ===== src/wsmt_ram.sv =====
module wsmt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/wsmt_div.sv =====
// Signed by unsigned restoring divider, one quotient bit per cycle,
// quotient truncated toward zero.
module wsmt_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  wsmt_pkg::div_req_t                req,
  output logic                              done,
  output logic signed [wsmt_pkg::NUM_W-1:0] quo
);

  logic                               busy_r;
  logic                               done_r;
  logic [wsmt_pkg::DCNT_W-1:0]        cnt_r;
  logic [wsmt_pkg::DEN_W-1:0]         rem_r;
  logic [wsmt_pkg::DEN_W-1:0]         rem_nxt;
  logic [wsmt_pkg::NUM_W-1:0]         quo_r;
  logic [wsmt_pkg::NUM_W-1:0]         quo_nxt;
  logic [wsmt_pkg::DEN_W-1:0]         den_r;
  logic                               neg_r;
  logic [wsmt_pkg::DEN_W:0]           shifted;
  logic [wsmt_pkg::DEN_W+1:0]         trial;
  logic                               fit;
  logic [wsmt_pkg::NUM_W-1:0]         mag;

  always_comb begin
    shifted = {rem_r, quo_r[wsmt_pkg::NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, den_r};
    fit     = ~trial[wsmt_pkg::DEN_W+1];
    rem_nxt = fit ? trial[wsmt_pkg::DEN_W-1:0] : shifted[wsmt_pkg::DEN_W-1:0];
    quo_nxt = {quo_r[wsmt_pkg::NUM_W-2:0], fit};
    mag     = req.num[wsmt_pkg::NUM_W-1] ? -req.num : req.num;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= wsmt_pkg::DCNT_W'(wsmt_pkg::NUM_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == wsmt_pkg::DCNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg_r <= req.num[wsmt_pkg::NUM_W-1];
      quo_r <= mag;
      rem_r <= '0;
      den_r <= req.den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(quo_r) : $signed(quo_r);

endmodule

// ===== src/weighted_second_moment_tensor.sv =====
// Channel  Dir  Payload                                     Handshake
// in_pt    in   pos_x, pos_y, pos_z, weight, last_point     valid/ready
// out_el   out  row, col, value, status, last_element       valid/ready
// cfg      in   cfg_wdata (tensor_form)                     cfg_we
//
// Points load at one item per cycle into two single-port-write RAMs.
// After the last point: a pass over the n stored points, three centroid
// divisions (one quotient bit per cycle), a second pass, six more
// divisions in covariance form, a saturation step, then nine result
// items. in_pt is also open while results drain; a last point taken
// then starts the next set afterwards. Reset clears control only; the
// point RAMs need no clearing.
module weighted_second_moment_tensor (
  input  logic       clk,
  input  logic       rst_n,
  wsmt_in_if.sink    in_pt,
  wsmt_out_if.source out_el,
  input  logic       cfg_we,
  input  logic       cfg_wdata
);

  wsmt_pkg::state_t state_r, state_nxt;

  logic                          cfg_form_r;
  logic                          form_r, form_nxt;
  logic                          pend_r, pend_nxt;
  logic [wsmt_pkg::CNT_W-1:0]    cnt_r, cnt_nxt, cnt_inc;
  logic                          ovf_r, ovf_nxt;
  logic [wsmt_pkg::CNT_W-1:0]    n_r, n_nxt;
  logic [wsmt_pkg::CNT_W-1:0]    iss_r, iss_nxt;
  logic [4:0]                    pipe_r, pipe_nxt;
  logic [2:0]                    idx_r, idx_nxt;
  logic                          dbusy_r, dbusy_nxt;
  logic [wsmt_pkg::ELEM_W-1:0]   e_r, e_nxt;
  logic                          zero_r, zero_nxt;
  logic [1:0]                    stat_r, stat_nxt;

  logic signed [wsmt_pkg::SUM_W-1:0] sum_r [3];
  logic signed [wsmt_pkg::SUM_W-1:0] sum_nxt [3];
  logic [wsmt_pkg::TOT_W-1:0]        tot_r, tot_nxt;
  logic signed [wsmt_pkg::CRD_W-1:0] cen_r [3];
  logic signed [wsmt_pkg::CRD_W-1:0] cen_nxt [3];
  logic signed [wsmt_pkg::ACC_W-1:0] acc_r [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::ACC_W-1:0] acc_nxt [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::VAL_W-1:0] res_r [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::VAL_W-1:0] res_nxt [wsmt_pkg::NUM_U];

  // pipeline registers
  logic signed [wsmt_pkg::P1_W-1:0]  p1_r [3];
  logic signed [wsmt_pkg::P1_W-1:0]  p1_nxt [3];
  logic [wsmt_pkg::WGT_W-1:0]        weff_r, weff_nxt;
  logic signed [wsmt_pkg::D_W-1:0]   d_r [3];
  logic signed [wsmt_pkg::D_W-1:0]   d_nxt [3];
  logic signed [wsmt_pkg::PRD_W-1:0] pr_r [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::PRD_W-1:0] pr_nxt [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::F_W-1:0]   f_r [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::F_W-1:0]   f_nxt [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::WF_W-1:0]  wf_r [wsmt_pkg::NUM_U];
  logic signed [wsmt_pkg::WF_W-1:0]  wf_nxt [wsmt_pkg::NUM_U];
  logic [wsmt_pkg::WGT_W-1:0]        w1_r, w1_nxt, w2_r, w2_nxt, w3_r, w3_nxt;

  logic                              in_acc, out_acc, has_room, last_acc;
  logic                              issue, pass_end, go_sum, clr_sum, clr_acc;
  logic [wsmt_pkg::CRD3_W-1:0]       crd_rd;
  logic [wsmt_pkg::WGT_W-1:0]        wgt_rd;
  logic signed [wsmt_pkg::CRD_W-1:0] crd [3];
  wsmt_pkg::div_req_t                div_req;
  logic                              div_done;
  logic signed [wsmt_pkg::NUM_W-1:0] div_quo;
  logic [wsmt_pkg::NUM_U-1:0]        sat_k;
  wsmt_pkg::elem_t                   el;

  assign in_pt.ready = (state_r == wsmt_pkg::ST_LOAD || state_r == wsmt_pkg::ST_EMIT)
                       && !pend_r;
  assign in_acc   = in_pt.valid & in_pt.ready;
  assign last_acc = in_acc & in_pt.last_point;
  assign out_acc  = out_el.valid & out_el.ready;
  assign has_room = cnt_r < wsmt_pkg::CNT_W'(wsmt_pkg::MAX_POINTS);
  assign cnt_inc  = has_room ? cnt_r + 1'b1 : cnt_r;

  assign issue    = (state_r == wsmt_pkg::ST_SUM || state_r == wsmt_pkg::ST_MOM)
                    && (iss_r != n_r);
  assign pass_end = (iss_r == n_r) && (pipe_r == '0);

  wsmt_ram #(.WIDTH(wsmt_pkg::CRD3_W), .DEPTH(wsmt_pkg::MAX_POINTS)) u_crd_ram (
    .clk   (clk),
    .we    (in_acc & has_room),
    .waddr (cnt_r[wsmt_pkg::ADDR_W-1:0]),
    .wdata ({in_pt.pos_z, in_pt.pos_y, in_pt.pos_x}),
    .raddr (iss_r[wsmt_pkg::ADDR_W-1:0]),
    .rdata (crd_rd)
  );

  wsmt_ram #(.WIDTH(wsmt_pkg::WGT_W), .DEPTH(wsmt_pkg::MAX_POINTS)) u_wgt_ram (
    .clk   (clk),
    .we    (in_acc & has_room),
    .waddr (cnt_r[wsmt_pkg::ADDR_W-1:0]),
    .wdata (in_pt.weight),
    .raddr (iss_r[wsmt_pkg::ADDR_W-1:0]),
    .rdata (wgt_rd)
  );

  always_comb begin
    div_req.start = (state_r == wsmt_pkg::ST_CDIV || state_r == wsmt_pkg::ST_NDIV)
                    && !dbusy_r;
    if (state_r == wsmt_pkg::ST_CDIV) begin
      div_req.num = wsmt_pkg::NUM_W'(sum_r[idx_r[1:0]]);
      div_req.den = tot_r;
    end else begin
      div_req.num = $signed(acc_r[idx_r][wsmt_pkg::NUM_W-1:0]);
      div_req.den = wsmt_pkg::DEN_W'(n_r);
    end
  end

  wsmt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quo   (div_quo)
  );

  // control sequencer
  always_comb begin
    state_nxt = state_r;
    form_nxt  = form_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    ovf_nxt   = ovf_r;
    n_nxt     = n_r;
    iss_nxt   = iss_r;
    idx_nxt   = idx_r;
    dbusy_nxt = dbusy_r;
    e_nxt     = e_r;
    zero_nxt  = zero_r;
    stat_nxt  = stat_r;
    pipe_nxt  = {pipe_r[3:0], issue};
    go_sum    = 1'b0;
    clr_sum   = 1'b0;
    clr_acc   = 1'b0;

    if (in_acc) begin
      cnt_nxt = cnt_inc;
      ovf_nxt = ovf_r | ~has_room;
      if (in_pt.last_point) begin
        n_nxt    = cnt_inc;
        form_nxt = cfg_form_r;
      end
    end
    if (issue) begin
      iss_nxt = iss_r + 1'b1;
    end

    case (state_r)
      wsmt_pkg::ST_LOAD: begin
        if (last_acc) go_sum = 1'b1;
      end
      wsmt_pkg::ST_SUM: begin
        if (pass_end) begin
          zero_nxt  = (tot_r == '0);
          idx_nxt   = '0;
          dbusy_nxt = 1'b0;
          state_nxt = (tot_r == '0) ? wsmt_pkg::ST_SAT : wsmt_pkg::ST_CDIV;
        end
      end
      wsmt_pkg::ST_CDIV: begin
        if (!dbusy_r) begin
          dbusy_nxt = 1'b1;
        end else if (div_done) begin
          dbusy_nxt = 1'b0;
          idx_nxt   = idx_r + 1'b1;
          if (idx_r == 3'd2) begin
            idx_nxt   = '0;
            iss_nxt   = '0;
            clr_acc   = 1'b1;
            state_nxt = wsmt_pkg::ST_MOM;
          end
        end
      end
      wsmt_pkg::ST_MOM: begin
        if (pass_end) begin
          idx_nxt   = '0;
          state_nxt = form_r ? wsmt_pkg::ST_NDIV : wsmt_pkg::ST_SAT;
        end
      end
      wsmt_pkg::ST_NDIV: begin
        if (!dbusy_r) begin
          dbusy_nxt = 1'b1;
        end else if (div_done) begin
          dbusy_nxt = 1'b0;
          idx_nxt   = idx_r + 1'b1;
          if (idx_r == 3'(wsmt_pkg::NUM_U - 1)) begin
            idx_nxt   = '0;
            state_nxt = wsmt_pkg::ST_SAT;
          end
        end
      end
      wsmt_pkg::ST_SAT: begin
        if (zero_r) stat_nxt = wsmt_pkg::STAT_EMPTY;
        else if (ovf_r) stat_nxt = wsmt_pkg::STAT_DROP;
        else if (|sat_k) stat_nxt = wsmt_pkg::STAT_SAT;
        else stat_nxt = wsmt_pkg::STAT_OK;
        cnt_nxt   = '0;
        ovf_nxt   = 1'b0;
        e_nxt     = '0;
        state_nxt = wsmt_pkg::ST_EMIT;
      end
      wsmt_pkg::ST_EMIT: begin
        if (last_acc) pend_nxt = 1'b1;
        if (out_acc) begin
          e_nxt = e_r + 1'b1;
          if (e_r == wsmt_pkg::ELEM_W'(wsmt_pkg::ELEMS - 1)) begin
            e_nxt = '0;
            if (pend_r || last_acc) go_sum = 1'b1;
            else state_nxt = wsmt_pkg::ST_LOAD;
          end
        end
      end
      default: state_nxt = wsmt_pkg::ST_LOAD;
    endcase

    if (go_sum) begin
      state_nxt = wsmt_pkg::ST_SUM;
      pend_nxt  = 1'b0;
      iss_nxt   = '0;
      clr_sum   = 1'b1;
    end
  end

  // datapath
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      crd[k] = crd_rd[k*wsmt_pkg::CRD_W +: wsmt_pkg::CRD_W];
    end
    weff_nxt = form_r ? wsmt_pkg::WGT_W'(1) : wgt_rd;
    w1_nxt   = wgt_rd;
    w2_nxt   = w1_r;
    w3_nxt   = w2_r;
    for (int k = 0; k < 3; k++) begin
      p1_nxt[k] = $signed({1'b0, weff_nxt}) * crd[k];
      d_nxt[k]  = wsmt_pkg::D_W'(crd[k]) - wsmt_pkg::D_W'(cen_r[k]);
    end

    pr_nxt[wsmt_pkg::U_XX] = d_r[0] * d_r[0];
    pr_nxt[wsmt_pkg::U_YY] = d_r[1] * d_r[1];
    pr_nxt[wsmt_pkg::U_ZZ] = d_r[2] * d_r[2];
    pr_nxt[wsmt_pkg::U_XY] = d_r[0] * d_r[1];
    pr_nxt[wsmt_pkg::U_XZ] = d_r[0] * d_r[2];
    pr_nxt[wsmt_pkg::U_YZ] = d_r[1] * d_r[2];

    if (form_r) begin
      for (int k = 0; k < wsmt_pkg::NUM_U; k++) begin
        f_nxt[k] = wsmt_pkg::F_W'(pr_r[k]);
      end
    end else begin
      // inertia: diagonal takes the other two squares, off-diagonal negated
      f_nxt[wsmt_pkg::U_XX] = wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_YY])
                            + wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_ZZ]);
      f_nxt[wsmt_pkg::U_YY] = wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_XX])
                            + wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_ZZ]);
      f_nxt[wsmt_pkg::U_ZZ] = wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_XX])
                            + wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_YY]);
      f_nxt[wsmt_pkg::U_XY] = -wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_XY]);
      f_nxt[wsmt_pkg::U_XZ] = -wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_XZ]);
      f_nxt[wsmt_pkg::U_YZ] = -wsmt_pkg::F_W'(pr_r[wsmt_pkg::U_YZ]);
    end

    for (int k = 0; k < wsmt_pkg::NUM_U; k++) begin
      if (form_r) wf_nxt[k] = wsmt_pkg::WF_W'(f_r[k]);
      else        wf_nxt[k] = $signed({1'b0, w3_r}) * f_r[k];
    end

    sum_nxt = sum_r;
    tot_nxt = tot_r;
    cen_nxt = cen_r;
    acc_nxt = acc_r;
    res_nxt = res_r;

    if (clr_sum) begin
      for (int k = 0; k < 3; k++) sum_nxt[k] = '0;
      tot_nxt = '0;
    end else if (state_r == wsmt_pkg::ST_SUM && pipe_r[1]) begin
      for (int k = 0; k < 3; k++) sum_nxt[k] = sum_r[k] + wsmt_pkg::SUM_W'(p1_r[k]);
      tot_nxt = tot_r + wsmt_pkg::TOT_W'(weff_r);
    end

    if (clr_acc) begin
      for (int k = 0; k < wsmt_pkg::NUM_U; k++) acc_nxt[k] = '0;
    end else if (state_r == wsmt_pkg::ST_MOM && pipe_r[4]) begin
      for (int k = 0; k < wsmt_pkg::NUM_U; k++) begin
        acc_nxt[k] = acc_r[k] + wsmt_pkg::ACC_W'(wf_r[k]);
      end
    end

    if (div_done && state_r == wsmt_pkg::ST_CDIV) begin
      cen_nxt[idx_r[1:0]] = div_quo[wsmt_pkg::CRD_W-1:0];
    end
    if (div_done && state_r == wsmt_pkg::ST_NDIV) begin
      res_nxt[idx_r] = wsmt_pkg::VAL_W'(div_quo);
    end

    for (int k = 0; k < wsmt_pkg::NUM_U; k++) begin
      sat_k[k] = !zero_r && !form_r
                 && !(&acc_r[k][wsmt_pkg::ACC_W-1:wsmt_pkg::VAL_W-1])
                 && (|acc_r[k][wsmt_pkg::ACC_W-1:wsmt_pkg::VAL_W-1]);
      if (state_r == wsmt_pkg::ST_SAT) begin
        if (zero_r) res_nxt[k] = '0;
        else if (!form_r) begin
          if (sat_k[k]) begin
            res_nxt[k] = acc_r[k][wsmt_pkg::ACC_W-1] ? wsmt_pkg::VAL_MIN : wsmt_pkg::VAL_MAX;
          end else begin
            res_nxt[k] = acc_r[k][wsmt_pkg::VAL_W-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= wsmt_pkg::ST_LOAD;
      cfg_form_r <= 1'b0;
      form_r     <= 1'b0;
      pend_r     <= 1'b0;
      cnt_r      <= '0;
      ovf_r      <= 1'b0;
      n_r        <= '0;
      iss_r      <= '0;
      pipe_r     <= '0;
      idx_r      <= '0;
      dbusy_r    <= 1'b0;
      e_r        <= '0;
      zero_r     <= 1'b0;
      stat_r     <= wsmt_pkg::STAT_OK;
    end else begin
      state_r    <= state_nxt;
      if (cfg_we) cfg_form_r <= cfg_wdata;
      form_r     <= form_nxt;
      pend_r     <= pend_nxt;
      cnt_r      <= cnt_nxt;
      ovf_r      <= ovf_nxt;
      n_r        <= n_nxt;
      iss_r      <= iss_nxt;
      pipe_r     <= pipe_nxt;
      idx_r      <= idx_nxt;
      dbusy_r    <= dbusy_nxt;
      e_r        <= e_nxt;
      zero_r     <= zero_nxt;
      stat_r     <= stat_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r  <= sum_nxt;
    tot_r  <= tot_nxt;
    cen_r  <= cen_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
    p1_r   <= p1_nxt;
    weff_r <= weff_nxt;
    d_r    <= d_nxt;
    pr_r   <= pr_nxt;
    f_r    <= f_nxt;
    wf_r   <= wf_nxt;
    w1_r   <= w1_nxt;
    w2_r   <= w2_nxt;
    w3_r   <= w3_nxt;
  end

  assign el                  = wsmt_pkg::elem_map(e_r);
  assign out_el.valid        = (state_r == wsmt_pkg::ST_EMIT);
  assign out_el.row          = el.row;
  assign out_el.col          = el.col;
  assign out_el.value        = res_r[el.u];
  assign out_el.status       = stat_r;
  assign out_el.last_element = (e_r == wsmt_pkg::ELEM_W'(wsmt_pkg::ELEMS - 1));

endmodule

// ===== src/wsmt_chk.sv =====
module wsmt_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        out_row,
  input logic [1:0]                        out_col,
  input logic signed [wsmt_pkg::VAL_W-1:0] out_value,
  input logic [1:0]                        out_status,
  input logic                              out_last
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row)
                                && $stable(out_col))
    else $error("result item changed while stalled");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_row == 2'd2 && out_col == 2'd2)
    else $error("last element not at row 2 col 2");

  a_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_row != 2'd3 && out_col != 2'd3)
    else $error("tensor index out of range");

  a_stat_same: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_valid && out_status == $past(out_status))
    else $error("status differs within one tensor");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == wsmt_pkg::STAT_EMPTY |-> out_value == '0)
    else $error("empty set with nonzero element");

endmodule

bind weighted_second_moment_tensor wsmt_chk u_wsmt_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_el.valid),
  .out_ready  (out_el.ready),
  .out_row    (out_el.row),
  .out_col    (out_el.col),
  .out_value  (out_el.value),
  .out_status (out_el.status),
  .out_last   (out_el.last_element)
);

// ===== verif/wsmt_checker.sv =====
`timescale 1ns / 100ps

module wsmt_checker (
  input  logic clk,
  input  logic rst_n,
  wsmt_in_if   in_mon,
  wsmt_out_if  out_mon,
  input  logic cfg_we,
  input  logic cfg_wdata,
  output int   errors,
  output int   pending
);

  typedef struct {
    logic [1:0]                        row;
    logic [1:0]                        col;
    logic signed [wsmt_pkg::VAL_W-1:0] value;
    logic [1:0]                        status;
    logic                              last_element;
  } tensor_elem_t;

  tensor_elem_t elem_q[$];

  longint pt_crd[wsmt_pkg::MAX_POINTS][3];
  longint pt_wgt[wsmt_pkg::MAX_POINTS];
  int     pt_cnt;
  logic   pt_dropped;
  logic   form_cov;

  assign pending = elem_q.size();

  // builds the nine tensor elements of the loaded set
  task automatic predict_tensor();
    longint sum[3];
    longint cen[3];
    longint tot, w, f, s, wf;
    longint d[3];
    logic signed [127:0] acc;
    logic signed [wsmt_pkg::VAL_W-1:0] val[9];
    logic [1:0] stat;
    logic sat;
    tensor_elem_t el;
    sum = '{0, 0, 0};
    tot = 0;
    sat = 1'b0;
    for (int e = 0; e < 9; e++) val[e] = '0;
    for (int i = 0; i < pt_cnt; i++) begin
      w = form_cov ? 1 : pt_wgt[i];
      for (int k = 0; k < 3; k++) sum[k] += w * pt_crd[i][k];
      tot += w;
    end
    if (pt_cnt == 0 || tot == 0) begin
      stat = wsmt_pkg::STAT_EMPTY;
    end else begin
      for (int k = 0; k < 3; k++) cen[k] = sum[k] / tot;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          if (form_cov) begin
            s = 0;
            for (int i = 0; i < pt_cnt; i++)
              s += (pt_crd[i][a] - cen[a]) * (pt_crd[i][b] - cen[b]);
            val[a*3+b] = s / longint'(pt_cnt);
          end else begin
            acc = '0;
            for (int i = 0; i < pt_cnt; i++) begin
              for (int k = 0; k < 3; k++) d[k] = pt_crd[i][k] - cen[k];
              if (a == b) f = d[0]*d[0] + d[1]*d[1] + d[2]*d[2] - d[a]*d[a];
              else        f = -(d[a] * d[b]);
              wf = pt_wgt[i] * f;
              acc += wf;
            end
            if (acc[127:63] == '0 || acc[127:63] == '1) begin
              val[a*3+b] = acc[63:0];
            end else begin
              val[a*3+b] = acc[127] ? wsmt_pkg::VAL_MIN : wsmt_pkg::VAL_MAX;
              sat = 1'b1;
            end
          end
        end
      end
      stat = pt_dropped ? wsmt_pkg::STAT_DROP
                        : (sat ? wsmt_pkg::STAT_SAT : wsmt_pkg::STAT_OK);
    end
    for (int e = 0; e < 9; e++) begin
      el.row          = 2'(e / 3);
      el.col          = 2'(e % 3);
      el.value        = val[e];
      el.status       = stat;
      el.last_element = (e == 8);
      elem_q.insert(elem_q.size(), el);
    end
  endtask

  always @(posedge clk) begin
    tensor_elem_t ex;
    if (!rst_n) begin
      pt_cnt     = 0;
      pt_dropped = 1'b0;
      form_cov   = 1'b0;
      errors     = 0;
    end else begin
      if (cfg_we) form_cov = cfg_wdata;
      if (in_mon.valid && in_mon.ready) begin
        if (pt_cnt < wsmt_pkg::MAX_POINTS) begin
          pt_crd[pt_cnt][0] = in_mon.pos_x;
          pt_crd[pt_cnt][1] = in_mon.pos_y;
          pt_crd[pt_cnt][2] = in_mon.pos_z;
          pt_wgt[pt_cnt]    = in_mon.weight;
          pt_cnt++;
        end else begin
          pt_dropped = 1'b1;
        end
        if (in_mon.last_point) begin
          predict_tensor();
          pt_cnt     = 0;
          pt_dropped = 1'b0;
        end
      end
      if (out_mon.valid && out_mon.ready) begin
        if (elem_q.size() == 0) begin
          $display("%0t: unexpected element row %0d col %0d value %0d", $time,
                   out_mon.row, out_mon.col, out_mon.value);
          errors++;
        end else begin
          ex = elem_q.pop_front();
          if (out_mon.row !== ex.row || out_mon.col !== ex.col ||
              out_mon.value !== ex.value || out_mon.status !== ex.status ||
              out_mon.last_element !== ex.last_element) begin
            $display("%0t: mismatch expected r%0d c%0d v%0d s%0d l%0d", $time,
                     ex.row, ex.col, ex.value, ex.status, ex.last_element);
            $display("%0t:            actual r%0d c%0d v%0d s%0d l%0d", $time,
                     out_mon.row, out_mon.col, out_mon.value, out_mon.status,
                     out_mon.last_element);
            errors++;
          end
        end
      end
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

  localparam int CYCLE_LIMIT = 600000;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;
  int   errors;
  int   pending;
  int   cycles;
  logic idle_on;
  logic hold_req;
  int   hold_left;
  int   stall_left;

  wsmt_in_if  in_pt ();
  wsmt_out_if out_el ();

  weighted_second_moment_tensor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pt     (in_pt),
    .out_el    (out_el),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  wsmt_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_pt),
    .out_mon   (out_el),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .errors    (errors),
    .pending   (pending)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("weighted_second_moment_tensor regression: fail");
      $finish;
    end
  end

  // result side: random stalls plus one long hold-off on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = 1500;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_el.ready = 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_el.ready = 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left   = $urandom_range(1, 19) - 1;
      out_el.ready = 1'b0;
    end else begin
      out_el.ready = 1'b1;
    end
  end

  task automatic send_point(input logic signed [wsmt_pkg::CRD_W-1:0] x, y, z,
                            input logic [wsmt_pkg::WGT_W-1:0] w, input logic last);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_pt.valid = 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_pt.valid      = 1'b1;
    in_pt.pos_x      = x;
    in_pt.pos_y      = y;
    in_pt.pos_z      = z;
    in_pt.weight     = w;
    in_pt.last_point = last;
    do @(posedge clk); while (!in_pt.ready);
    @(negedge clk);
  endtask

  function automatic logic signed [wsmt_pkg::CRD_W-1:0] rand_crd(input int kind);
    case (kind)
      0:       return wsmt_pkg::CRD_W'($urandom);
      1:       return wsmt_pkg::CRD_W'($signed(11'($urandom)));
      default: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
    endcase
  endfunction

  // kind 0 full range, 1 small coordinates, 2 extremes at full weight
  task automatic send_set(input int n, input int kind);
    logic [wsmt_pkg::WGT_W-1:0] w;
    for (int i = 0; i < n; i++) begin
      case (kind)
        2:       w = 16'hFFFF;
        default: w = ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom);
      endcase
      send_point(rand_crd(kind), rand_crd(kind), rand_crd(kind), w, i == n - 1);
    end
  endtask

  task automatic drain();
    in_pt.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_form(input logic f);
    drain();
    cfg_we    = 1'b1;
    cfg_wdata = f;
    @(negedge clk);
    cfg_we    = 1'b0;
    @(negedge clk);
  endtask

  task automatic directed_sets();
    send_point(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 16'hFFFF, 1'b1);
    send_point(20'sh80000, 20'sh7FFFF, 20'sh00000, 16'h0000, 1'b0);
    send_point(20'sh7FFFF, 20'sh80000, 20'sh7FFFF, 16'hFFFF, 1'b1);
    // zero total weight
    send_point(20'sh00123, 20'sh80000, 20'sh7FFFF, 16'h0000, 1'b0);
    send_point(20'sh7FFFF, 20'sh00001, 20'sh80000, 16'h0000, 1'b1);
    send_point(20'sh00001, 20'sh00000, 20'shFFFFF, 16'h0001, 1'b0);
    send_point(20'shFFFFF, 20'sh00001, 20'sh00000, 16'h0100, 1'b0);
    send_point(20'sh00000, 20'shFFFFF, 20'sh00001, 16'hFFFF, 1'b1);
  endtask

  initial begin
    int sets;
    cycles      = 0;
    idle_on     = 1'b1;
    hold_req    = 1'b0;
    hold_left   = 0;
    stall_left  = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_wdata   = 1'b0;
    in_pt.valid = 1'b0;
    in_pt.pos_x = '0;
    in_pt.pos_y = '0;
    in_pt.pos_z = '0;
    in_pt.weight = '0;
    in_pt.last_point = 1'b0;
    out_el.ready = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    set_form(1'b0);
    directed_sets();
    set_form(1'b1);
    directed_sets();

    // back-pressure: results held while further sets are offered
    drain();
    hold_req = 1'b1;
    send_set(12, 0);
    send_set(5, 1);
    send_set(3, 0);

    sets = 0;
    repeat (48) begin
      if (sets % 12 == 0) set_form(sets % 24 == 0);
      if (sets == 36) begin
        set_form(1'b1);
        idle_on = 1'b0;
      end
      send_set($urandom_range(1, 8), $urandom_range(0, 9) == 0 ? 2 : $urandom_range(0, 1));
      sets++;
    end
    drain();
    repeat (50) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("weighted_second_moment_tensor regression: pass");
    end else begin
      $display("weighted_second_moment_tensor regression: fail");
    end
    $finish;
  end

endmodule
